[src/hcs_pkg.sv]
// Shared types and constants for the Hamiltonian cycle search unit.
package hcs_pkg;

	localparam int DEF_MAX_VERTICES = 8;

	localparam int VCOUNT_W   = 4;
	localparam int ROW_IDX_W  = 3;
	localparam int ROW_W      = 8;
	localparam int VERTEX_W   = 3;
	localparam int POSITION_W = 3;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 4'd8;

	typedef enum logic [2:0] {
		ST_LOAD   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic emit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic found;
		logic fail;
		logic emit_last;
		logic out_full;
	} dp_sts_t;

endpackage

[src/hcs_ctrl.sv]
// Sequencer for row loading, backtracking search and result emission.
module hcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_row,
	input  logic             out_ready,
	input  hcs_pkg::dp_sts_t sts,
	output hcs_pkg::dp_cmd_t cmd,
	output logic             in_ready,
	output logic             cfg_ready
);
	import hcs_pkg::*;

	state_t state_q, state_d;
	logic   slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// output slot can take a result when empty or being drained this cycle
	assign slot_free = !sts.out_full || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && last_row) begin
					cmd.start = 1'b1;
					state_d   = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
				if (sts.found || sts.fail) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_LOAD);
	assign cfg_ready = (state_q == ST_LOAD);

endmodule

[src/hcs_datapath.sv]
// Adjacency store, path stack, visited mask and output register of the search.
module hcs_datapath #(
	parameter int MAX_VERTICES = hcs_pkg::DEF_MAX_VERTICES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hcs_pkg::dp_cmd_t                cmd,
	input  logic                            cfg_we,
	input  logic [hcs_pkg::VCOUNT_W-1:0]    vertex_count,
	input  logic [hcs_pkg::ROW_IDX_W-1:0]   row_index,
	input  logic [hcs_pkg::ROW_W-1:0]       adjacency_row,
	input  logic                            out_ready,
	output hcs_pkg::dp_sts_t                sts,
	output logic                            out_valid,
	output logic [hcs_pkg::VERTEX_W-1:0]    vertex,
	output logic [hcs_pkg::POSITION_W-1:0]  position,
	output logic                            cycle_found,
	output logic                            last_result
);
	import hcs_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [VCOUNT_W-1:0]     vcount_q;
	logic [VW-1:0]           stk_q [MAX_VERTICES];  // stk_q[0] is the path tip
	logic [MAX_VERTICES-1:0] visited_q;
	logic [CW-1:0]           depth_q;
	logic [CW-1:0]           cand_q;                // next candidate at the tip level
	logic [VW-1:0]           emit_cnt_q;
	logic                    found_q;

	logic                    out_valid_q;
	logic [VERTEX_W-1:0]     vertex_q;
	logic [POSITION_W-1:0]   position_q;
	logic                    cycle_found_q;
	logic                    last_result_q;

	logic [CW-1:0]           n_w;
	logic [MAX_VERTICES-1:0] tip_row;
	logic [MAX_VERTICES-1:0] cand_ok;
	logic [VW-1:0]           pick_v;
	logic                    any_cand;
	logic                    at_full;
	logic                    do_push;
	logic                    do_pop;
	logic                    row_in_range;
	logic [CW-1:0]           emit_pos;
	logic [VW-1:0]           emit_idx;

	// vertex count clamped to [2, MAX_VERTICES]
	always_comb begin
		if (int'(vcount_q) < 2) begin
			n_w = CW'(2);
		end else if (int'(vcount_q) > MAX_VERTICES) begin
			n_w = CW'(MAX_VERTICES);
		end else begin
			n_w = CW'(vcount_q);
		end
	end

	assign tip_row = adj_mem[stk_q[0]];
	assign at_full = (depth_q == n_w);

	// lowest unvisited neighbor of the tip at or above the candidate pointer
	always_comb begin
		cand_ok = '0;
		pick_v  = '0;
		for (int v = 0; v < MAX_VERTICES; v++) begin
			cand_ok[v] = tip_row[v] && !visited_q[v] &&
				(v >= int'(cand_q)) && (v < int'(n_w));
		end
		for (int v = MAX_VERTICES - 1; v >= 0; v--) begin
			if (cand_ok[v]) begin
				pick_v = VW'(v);
			end
		end
	end

	assign any_cand = |cand_ok;
	assign do_push  = cmd.step && !at_full && any_cand;
	assign do_pop   = cmd.step && (at_full ? !tip_row[0] : !any_cand);

	assign sts.found     = cmd.step && at_full && tip_row[0];
	assign sts.fail      = do_pop && (depth_q == CW'(1));
	assign sts.out_full  = out_valid_q;
	assign sts.emit_last = !found_q || (CW'(emit_cnt_q) == n_w - CW'(1));

	// path is stored tip first, so position k sits at n-1-k
	assign emit_pos = n_w - CW'(1) - CW'(emit_cnt_q);
	assign emit_idx = emit_pos[VW-1:0];

	assign row_in_range = (int'(row_index) < MAX_VERTICES);

	always_ff @(posedge clk) begin
		if (cmd.load && row_in_range) begin
			adj_mem[VW'(row_index)] <= MAX_VERTICES'(adjacency_row);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= vertex_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				stk_q[i] <= '0;
			end
			visited_q  <= '0;
			depth_q    <= CW'(1);
			cand_q     <= CW'(1);
			emit_cnt_q <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.start) begin
				stk_q[0]   <= '0;
				visited_q  <= MAX_VERTICES'(1);
				depth_q    <= CW'(1);
				cand_q     <= CW'(1);
				emit_cnt_q <= '0;
				found_q    <= 1'b0;
			end else if (do_push) begin
				stk_q[0] <= pick_v;
				for (int i = 1; i < MAX_VERTICES; i++) begin
					stk_q[i] <= stk_q[i-1];
				end
				visited_q[pick_v] <= 1'b1;
				depth_q           <= depth_q + CW'(1);
				cand_q            <= CW'(1);
			end else if (do_pop) begin
				for (int i = 0; i < MAX_VERTICES - 1; i++) begin
					stk_q[i] <= stk_q[i+1];
				end
				stk_q[MAX_VERTICES-1] <= '0;
				visited_q[stk_q[0]]   <= 1'b0;
				depth_q               <= depth_q - CW'(1);
				cand_q                <= CW'(stk_q[0]) + CW'(1);
			end
			if (sts.found) begin
				found_q <= 1'b1;
			end
			if (cmd.emit) begin
				emit_cnt_q <= emit_cnt_q + VW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			vertex_q      <= found_q ? VERTEX_W'(stk_q[emit_idx]) : '0;
			position_q    <= found_q ? POSITION_W'(emit_cnt_q) : '0;
			cycle_found_q <= found_q;
			last_result_q <= sts.emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign vertex      = vertex_q;
	assign position    = position_q;
	assign cycle_found = cycle_found_q;
	assign last_result = last_result_q;

endmodule

[src/hamiltonian_cycle_search_unit.sv]
// Top level of the Hamiltonian cycle search unit: controller plus datapath.
// Usage:
//   cfg channel (cfg_valid/cfg_ready, vertex_count) sets the number of vertices
//   searched, clamped to 2..MAX_VERTICES; taken only while the unit is idle.
//   in channel (in_valid/in_ready) carries one adjacency row per request;
//   rows load at one per cycle. A request with last_row set also starts the
//   search from vertex 0 once its row is stored.
//   out channel (out_valid/out_ready) returns the first cycle found as one
//   request per searched vertex, in path order (last_result on the final
//   one), or a single request with cycle_found low when no cycle exists.
// Search:
//   One tree step per cycle: a push, a pop (dead end or missing closing edge),
//   or the closing-edge hit that ends a found cycle. The number of tree steps
//   is data dependent and can grow exponentially with the vertex count.
//   in_ready is low throughout. out_valid rises once the controller is in its
//   emit state and the output register is loaded; results then leave at one
//   per cycle while out_ready stays high.
// Reset: arst_n clears the controller to idle, vertex_count to 8, and the path
//   stack and visited mask; stored rows are undefined until written.
// Stall: a held result stays put until out_ready; next-graph rows load meanwhile.
module hamiltonian_cycle_search_unit #(
	parameter int MAX_VERTICES = hcs_pkg::DEF_MAX_VERTICES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hcs_pkg::VCOUNT_W-1:0]    vertex_count,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [hcs_pkg::ROW_IDX_W-1:0]   row_index,
	input  logic [hcs_pkg::ROW_W-1:0]       adjacency_row,
	input  logic                            last_row,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hcs_pkg::VERTEX_W-1:0]    vertex,
	output logic [hcs_pkg::POSITION_W-1:0]  position,
	output logic                            cycle_found,
	output logic                            last_result
);
	import hcs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	hcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_row  (last_row),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.cfg_ready (cfg_ready)
	);

	hcs_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.vertex_count  (vertex_count),
		.row_index     (row_index),
		.adjacency_row (adjacency_row),
		.out_ready     (out_ready),
		.sts           (sts),
		.out_valid     (out_valid),
		.vertex        (vertex),
		.position      (position),
		.cycle_found   (cycle_found),
		.last_result   (last_result)
	);

endmodule

[src/hcs_checker.sv]
// Port-level assertions for the Hamiltonian cycle search unit, with its bind.
module hcs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            last_row,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [hcs_pkg::VERTEX_W-1:0]    vertex,
	input logic [hcs_pkg::POSITION_W-1:0]  position,
	input logic                            cycle_found,
	input logic                            last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex) && $stable(position) &&
			$stable(cycle_found) && $stable(last_result))
		else $error("stalled result changed");

	a_no_cycle_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cycle_found |-> last_result && vertex == '0 && position == '0)
		else $error("no-cycle answer malformed");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_row |=> !in_ready)
		else $error("input taken during search");

	a_path_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result |=>
			out_valid && cycle_found && position == $past(position) + 3'd1)
		else $error("cycle path broken");

endmodule

bind hamiltonian_cycle_search_unit hcs_checker u_hcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.last_row    (last_row),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.vertex      (vertex),
	.position    (position),
	.cycle_found (cycle_found),
	.last_result (last_result)
);
